>>> design/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants of the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

   // list geometry
   localparam int CAPACITY   = 32;
   localparam int VALUE_BITS = 32;

   // item field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // derived widths
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int WIDE_W = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_READ     = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADIDX = 2'd3
   } status_type;

   // what every cell does with its entry
   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_UP,
      SHIFT_DOWN
   } shift_type;

   typedef struct packed {
      shift_type              shift;
      logic [IDX_W-1:0]       pos;
      logic [VALUE_BITS-1:0]  value;
   } cell_ctrl_type;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
      logic                 data_en;
      logic [IDX_W-1:0]     rd_pos;
   } ctrl_rsp_type;

endpackage

>>> design/pida_if.sv
// ----------------------------------------------------------------------------
// pida_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface pida_req_if;
   import pida_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [INDEX_W-1:0]    index;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output index, output value, input ready);
   modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface pida_rsp_if;
   import pida_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [COUNT_W-1:0]       count;
   logic signed [DATA_W-1:0] data_out;

   modport source (output valid, output status, output count, output data_out, input ready);
   modport sink   (input valid, input status, input count, input data_out, output ready);
endinterface

>>> design/pida_cell.sv
// ----------------------------------------------------------------------------
// pida_cell
// One slot of the list: holds, loads the new value or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module pida_cell (
   input  logic                               clock,
   input  pida_pkg::cell_ctrl_type            ctrl,
   input  logic [pida_pkg::IDX_W-1:0]         cell_index,
   input  logic [pida_pkg::VALUE_BITS-1:0]    left_data,
   input  logic [pida_pkg::VALUE_BITS-1:0]    right_data,
   output logic [pida_pkg::VALUE_BITS-1:0]    data
);
   import pida_pkg::*;

   logic [VALUE_BITS-1:0] data_ff;
   logic [VALUE_BITS-1:0] data_in;

   // slot select for this cycle
   always_comb begin
      data_in = data_ff;
      unique case (ctrl.shift)
         SHIFT_UP: begin
            if (cell_index == ctrl.pos) begin
               data_in = ctrl.value;
            end else if (cell_index > ctrl.pos) begin
               data_in = left_data;
            end
         end
         SHIFT_DOWN: begin
            if (cell_index >= ctrl.pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // slot storage, no reset: entries are valid only below the count
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> design/pida_ctrl.sv
// ----------------------------------------------------------------------------
// pida_ctrl
// Fill count, operation checks and the shift command for the cell chain.
// ----------------------------------------------------------------------------
module pida_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic [pida_pkg::OP_W-1:0]        op,
   input  logic [pida_pkg::INDEX_W-1:0]     index,
   input  logic [pida_pkg::DATA_W-1:0]      value,
   output pida_pkg::cell_ctrl_type          cell_ctrl,
   output pida_pkg::ctrl_rsp_type           rsp
);
   import pida_pkg::*;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [CMP_W-1:0]      new_cnt;
   logic [WIDE_W-1:0]     value_wide;
   status_type            status;
   shift_type             shift;
   op_type                op_dec;

   assign op_dec     = op_type'(op);
   assign pos_ext    = CMP_W'(index);
   assign cnt_ext    = CMP_W'(count_ff);
   assign value_wide = WIDE_W'(value);

   // status and shift decision, full and empty checked before the index
   always_comb begin
      status = ST_BADIDX;
      shift  = SHIFT_NONE;
      unique case (op_dec)
         OP_INSERT: begin
            if (cnt_ext == CMP_W'(CAPACITY)) begin
               status = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status = ST_BADIDX;
            end else begin
               status = ST_OK;
               shift  = SHIFT_UP;
            end
         end
         OP_DELETE, OP_READ: begin
            if (cnt_ext == '0) begin
               status = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status = ST_BADIDX;
            end else begin
               status = ST_OK;
               if (op_dec == OP_DELETE) begin
                  shift = SHIFT_DOWN;
               end
            end
         end
         default: begin
            status = ST_BADIDX;
         end
      endcase
   end

   // count after the operation
   always_comb begin
      unique case (shift)
         SHIFT_UP:   new_cnt = cnt_ext + CMP_W'(1);
         SHIFT_DOWN: new_cnt = cnt_ext - CMP_W'(1);
         default:    new_cnt = cnt_ext;
      endcase
   end

   assign count_in = fire ? new_cnt[CNT_W-1:0] : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // command to the cells, only for an accepted item
   assign cell_ctrl.shift = fire ? shift : SHIFT_NONE;
   assign cell_ctrl.pos   = pos_ext[IDX_W-1:0];
   assign cell_ctrl.value = value_wide[VALUE_BITS-1:0];

   // result fields
   assign rsp.status  = status;
   assign rsp.count   = new_cnt[COUNT_W-1:0];
   assign rsp.data_en = (status == ST_OK) && (op_dec != OP_INSERT);
   assign rsp.rd_pos  = pos_ext[IDX_W-1:0];

endmodule

>>> design/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Bounded ordered list of signed values with insert, delete and read at an
// index; one result item per operation item.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY slot cells; an insert or delete moves
// every affected cell to its neighbor's entry in the same clock, so a new
// operation item is taken every cycle while the result register is empty or
// being drained. The result item is registered and appears in the cycle after
// its operation is accepted. The critical path is the index compare feeding
// the 32-way read select of the cell chain.
module positional_insert_delete_array (
   input  logic          clock,
   input  logic          reset,
   pida_req_if.sink      req_ch,
   pida_rsp_if.source    rsp_ch
);
   import pida_pkg::*;

   logic                   fire;
   cell_ctrl_type          cell_ctrl;
   ctrl_rsp_type           ctrl_rsp;
   logic [VALUE_BITS-1:0]  cell_data [CAPACITY];
   logic [VALUE_BITS-1:0]  rd_slot;
   logic [WIDE_W-1:0]      rd_wide;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic [DATA_W-1:0]      rsp_data_ff;
   logic [DATA_W-1:0]      rsp_data_in;

   // accept while the result register is free or being taken
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;

   pida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .op        (req_ch.op),
      .index     (req_ch.index),
      .value     (req_ch.value),
      .cell_ctrl (cell_ctrl),
      .rsp       (ctrl_rsp)
   );

   // chain of slot cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_BITS-1:0] left_data;
      logic [VALUE_BITS-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cell_ctrl.value;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      pida_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .cell_index (IDX_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   // read select of the addressed slot
   assign rd_slot     = cell_data[ctrl_rsp.rd_pos];
   assign rd_wide     = WIDE_W'(rd_slot);
   assign rsp_data_in = ctrl_rsp.data_en ? rd_wide[DATA_W-1:0] : '0;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= ctrl_rsp.status;
         rsp_count_ff  <= ctrl_rsp.count;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.count    = rsp_count_ff;
   assign rsp_ch.data_out = rsp_data_ff;

endmodule
